// ===== sv/lz_flag_group_decompressor_macros.svh =====
// Assertion macros used by the decompressor module.
`ifndef LZ_FLAG_GROUP_DECOMPRESSOR_MACROS_SVH
`define LZ_FLAG_GROUP_DECOMPRESSOR_MACROS_SVH

// Whenever the trigger holds, the property must hold in the same cycle.
`define LZFG_ASSERT_IMPL(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Whenever the trigger holds, the property must hold in the next cycle.
`define LZFG_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/lzfg_pkg.sv =====
`default_nettype none
package lzfg_pkg;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_bytes;
        logic [2:0]  byte_count;
        logic        run_last;
        logic        stream_done;
        logic [2:0]  status;
    } out_item_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_HEADER      = 3'd1;
    localparam logic [2:0] ST_LENGTH      = 3'd2;
    localparam logic [2:0] ST_REF_TRUNC   = 3'd3;
    localparam logic [2:0] ST_REF_INVALID = 3'd4;
    localparam logic [2:0] ST_LIT_TRUNC   = 3'd5;
    localparam logic [2:0] ST_SIZE        = 3'd6;
    localparam logic [2:0] ST_CHECKSUM    = 3'd7;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  MAGIC_0   = 8'h50;
    localparam logic [7:0]  MAGIC_1   = 8'h5A;
    localparam logic [7:0]  VER_LEGACY  = 8'h31;
    localparam logic [7:0]  VER_CURRENT = 8'h32;

endpackage
`default_nettype wire

// ===== sv/lz_flag_group_decompressor.sv =====
`default_nettype none
// LZSS flag-group decompressor with FNV-1a check.
// Input channel (in_valid/in_stall/in_data) carries one compressed byte per
// transfer, with end_of_stream on the final byte. Output channel
// (out_valid/out_stall/out_data) carries up to four decoded bytes per transfer.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes output_limit.
// A header byte, a flags byte or an offset byte gives no result unless it is
// the final byte of a stream. A literal is accepted, decoded and then given
// as a result. A back reference copies one byte per cycle from the history
// memory, whose single read port sets the rate, and pauses after each result
// of up to four bytes until it is delivered. The FNV-1a multiply steps once
// per decoded byte and runs in step with the copy. On the final byte of a
// stream the last result is held back until the status is registered.
// An item is accepted only when the previous item is fully delivered.
// Reset clears all stream state and sets output_limit to 65536; the history
// memory is not cleared, since a valid reference reads only bytes written
// in the same stream. When the receiver stalls, the pending result holds and
// decoding of further bytes waits. After the final byte the status is given
// with stream_done, and the header, size, position and error state is reset.
`include "lz_flag_group_decompressor_macros.svh"
module lz_flag_group_decompressor #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire lzfg_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output lzfg_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [31:0]          cfg_data
);
    localparam int AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WORK = 4'b0010,
        S_COPY = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] limit_reg;
    logic [3:0]  hpos_reg;
    logic        legacy_reg;
    logic [31:0] dsize_reg;
    logic [31:0] schk_reg;
    logic [31:0] prod_reg;
    logic [7:0]  fbits_reg;
    logic [3:0]  fidx_reg;
    logic [1:0]  phase_reg;
    logic [15:0] off_reg;
    logic [2:0]  err_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [7:0]  rem_reg;
    logic        rd_pend_reg;
    logic [31:0] word_reg;
    logic [2:0]  cnt_reg;
    logic        fin_reg;
    logic [2:0]  stat_reg;
    logic        cl_reg;
    logic        show;

    logic [7:0] ring [HISTORY_DEPTH];
    logic [7:0] rd_data;
    logic       rd_en;
    logic [AW-1:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_data;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;
    logic [7:0] copy_byte;

    logic        fnv_step;
    logic [31:0] fnv_sum;

    lzfg_fnv u_fnv (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cl_reg),
        .step  (fnv_step),
        .data  (wr_data),
        .sum   (fnv_sum)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring[prod_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= ring[rd_addr];
        end
        fwd_reg      <= rd_en && wr_en && (rd_addr == prod_reg[AW-1:0]);
        fwd_data_reg <= wr_data;
    end

    assign copy_byte = fwd_reg ? fwd_data_reg : rd_data;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT) && show;
    assign fnv_step  = wr_en;

    always_comb
    begin
        out_data.out_bytes   = word_reg;
        out_data.byte_count  = cnt_reg;
        out_data.run_last    = (rem_reg == 8'd0) && !rd_pend_reg;
        out_data.stream_done = fin_reg;
        out_data.status      = stat_reg;
    end

    logic [2:0] fstat;
    logic       tok_ref;
    logic [31:0] minlen;
    logic [32:0] endpos;
    logic        bad_ref;

    always_comb
    begin
        tok_ref = fbits_reg[fidx_reg[2:0]];
        minlen  = legacy_reg ? 32'd3 : 32'd4;
        endpos  = {1'b0, prod_reg} + {25'd0, byte_reg};
        bad_ref = (off_reg == 16'd0) || ({24'd0, byte_reg} < minlen) ||
                  ({16'd0, off_reg} > prod_reg) ||
                  ({16'd0, off_reg} > 32'(HISTORY_DEPTH)) ||
                  (endpos > {1'b0, dsize_reg});
        if (err_reg != lzfg_pkg::ST_OK)
            fstat = err_reg;
        else if (hpos_reg < 4'd12)
            fstat = lzfg_pkg::ST_HEADER;
        else if (prod_reg != dsize_reg)
        begin
            if (fidx_reg < 4'd8)
                fstat = (phase_reg != 2'd0 || tok_ref) ? lzfg_pkg::ST_REF_TRUNC
                                                       : lzfg_pkg::ST_LIT_TRUNC;
            else
                fstat = lzfg_pkg::ST_SIZE;
        end
        else
            fstat = (fnv_sum == schk_reg) ? lzfg_pkg::ST_OK : lzfg_pkg::ST_CHECKSUM;
    end

    logic [3:0]  hpos_next;
    logic        legacy_next;
    logic [31:0] dsize_next, schk_next, prod_next, word_next;
    logic [7:0]  fbits_next, rem_next;
    logic [3:0]  fidx_next;
    logic [1:0]  phase_next;
    logic [15:0] off_next;
    logic [2:0]  err_next, cnt_next, stat_next;
    logic        fin_next, rd_pend_next, cl_next;

    assign rd_addr = prod_next[AW-1:0] - off_reg[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        hpos_next    = hpos_reg;
        legacy_next  = legacy_reg;
        dsize_next   = dsize_reg;
        schk_next    = schk_reg;
        prod_next    = prod_reg;
        fbits_next   = fbits_reg;
        fidx_next    = fidx_reg;
        phase_next   = phase_reg;
        off_next     = off_reg;
        err_next     = err_reg;
        rem_next     = rem_reg;
        word_next    = word_reg;
        cnt_next     = cnt_reg;
        stat_next    = stat_reg;
        fin_next     = fin_reg;
        rd_pend_next = 1'b0;
        cl_next      = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = byte_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WORK;
                    word_next  = 32'd0;
                    cnt_next   = 3'd0;
                    fin_next   = 1'b0;
                    stat_next  = lzfg_pkg::ST_OK;
                end
            end
            S_WORK:
            begin
                state_next = S_OUT;
                if (err_reg == lzfg_pkg::ST_OK)
                begin
                    if (hpos_reg < 4'd12)
                    begin
                        hpos_next = hpos_reg + 4'd1;
                        case (hpos_reg)
                            4'd0: if (byte_reg != lzfg_pkg::MAGIC_0)
                                      err_next = lzfg_pkg::ST_HEADER;
                            4'd1: if (byte_reg != lzfg_pkg::MAGIC_1)
                                      err_next = lzfg_pkg::ST_HEADER;
                            4'd2:
                            begin
                                if (byte_reg == lzfg_pkg::VER_LEGACY)
                                    legacy_next = 1'b1;
                                else if (byte_reg == lzfg_pkg::VER_CURRENT)
                                    legacy_next = 1'b0;
                                else
                                    err_next = lzfg_pkg::ST_HEADER;
                            end
                            4'd3: if (byte_reg != 8'd0)
                                      err_next = lzfg_pkg::ST_HEADER;
                            4'd4, 4'd5, 4'd6, 4'd7:
                                dsize_next = dsize_reg |
                                    ({24'd0, byte_reg} << {hpos_reg[1:0], 3'd0});
                            default:
                                schk_next = schk_reg |
                                    ({24'd0, byte_reg} << {hpos_reg[1:0], 3'd0});
                        endcase
                        if (hpos_reg == 4'd11 && err_next == lzfg_pkg::ST_OK &&
                            (dsize_reg == 32'd0 || dsize_reg > limit_reg))
                            err_next = lzfg_pkg::ST_LENGTH;
                    end
                    else if (prod_reg == dsize_reg)
                        err_next = lzfg_pkg::ST_SIZE;
                    else if (fidx_reg >= 4'd8)
                    begin
                        fbits_next = byte_reg;
                        fidx_next  = 4'd0;
                        phase_next = 2'd0;
                    end
                    else if (!tok_ref)
                    begin
                        wr_en     = 1'b1;
                        prod_next = prod_reg + 32'd1;
                        word_next = {24'd0, byte_reg};
                        cnt_next  = 3'd1;
                        fidx_next = (prod_next == dsize_reg) ? 4'd8 : fidx_reg + 4'd1;
                    end
                    else if (phase_reg == 2'd0)
                    begin
                        off_next   = {8'd0, byte_reg};
                        phase_next = legacy_reg ? 2'd2 : 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        off_next   = {byte_reg, off_reg[7:0]};
                        phase_next = 2'd2;
                    end
                    else if (bad_ref)
                        err_next = lzfg_pkg::ST_REF_INVALID;
                    else
                    begin
                        rem_next     = byte_reg;
                        rd_en        = 1'b1;
                        rd_pend_next = 1'b1;
                        state_next   = S_COPY;
                    end
                end
                if (state_next == S_OUT && !last_reg && cnt_next == 3'd0)
                    state_next = S_IDLE;
            end
            S_COPY:
            begin
                wr_en     = 1'b1;
                wr_data   = copy_byte;
                prod_next = prod_reg + 32'd1;
                word_next = word_reg | ({24'd0, copy_byte} << {cnt_reg[1:0], 3'd0});
                cnt_next  = cnt_reg + 3'd1;
                rem_next  = rem_reg - 8'd1;
                if (rem_next != 8'd0 && cnt_next != 3'd4)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                    if (rem_next == 8'd0)
                    begin
                        phase_next = 2'd0;
                        fidx_next  = (prod_next == dsize_reg) ? 4'd8 : fidx_reg + 4'd1;
                    end
                end
            end
            S_OUT:
            begin
                if (last_reg && rem_reg == 8'd0 && !fin_reg)
                begin
                    fin_next  = 1'b1;
                    stat_next = fstat;
                end
                else if (!out_stall)
                begin
                    if (rem_reg != 8'd0)
                    begin
                        state_next   = S_COPY;
                        word_next    = 32'd0;
                        cnt_next     = 3'd0;
                        rd_en        = 1'b1;
                        rd_pend_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (last_reg)
                        begin
                            cl_next    = 1'b1;
                            hpos_next  = 4'd0;
                            legacy_next = 1'b0;
                            dsize_next = 32'd0;
                            schk_next  = 32'd0;
                            prod_next  = 32'd0;
                            fbits_next = 8'd0;
                            fidx_next  = 4'd8;
                            phase_next = 2'd0;
                            off_next   = 16'd0;
                            err_next   = lzfg_pkg::ST_OK;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result is offered only once its status is final.
    assign show = !(last_reg && rem_reg == 8'd0) || fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limit_reg   <= 32'd65536;
            hpos_reg    <= 4'd0;
            legacy_reg  <= 1'b0;
            dsize_reg   <= 32'd0;
            schk_reg    <= 32'd0;
            prod_reg    <= 32'd0;
            fbits_reg   <= 8'd0;
            fidx_reg    <= 4'd8;
            phase_reg   <= 2'd0;
            off_reg     <= 16'd0;
            err_reg     <= lzfg_pkg::ST_OK;
            rem_reg     <= 8'd0;
            rd_pend_reg <= 1'b0;
            last_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            cl_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hpos_reg    <= hpos_next;
            legacy_reg  <= legacy_next;
            dsize_reg   <= dsize_next;
            schk_reg    <= schk_next;
            prod_reg    <= prod_next;
            fbits_reg   <= fbits_next;
            fidx_reg    <= fidx_next;
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            err_reg     <= err_next;
            rem_reg     <= rem_next;
            rd_pend_reg <= rd_pend_next;
            fin_reg     <= fin_next;
            cl_reg      <= cl_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (state_reg == S_IDLE && in_valid)
                last_reg <= in_data.end_of_stream;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        stat_reg <= stat_next;
        if (state_reg == S_IDLE && in_valid)
            byte_reg <= in_data.stream_byte;
    end

    `LZFG_ASSERT_IMPL(a_cnt_range, clk, rst_n, out_valid, out_data.byte_count <= 3'd4,
        "byte count above four")
    `LZFG_ASSERT_IMPL(a_done_last, clk, rst_n, out_valid && out_data.stream_done,
        out_data.run_last, "stream_done without run_last")
    `LZFG_ASSERT_NEXT(a_copy_write, clk, rst_n, rd_en, state_reg == S_COPY,
        "memory read not followed by copy")
    `LZFG_ASSERT_IMPL(a_idle_quiet, clk, rst_n, state_reg == S_IDLE, !wr_en,
        "history written while idle")
endmodule
`default_nettype wire

// ===== sv/lzfg_fnv.sv =====
`default_nettype none
module lzfg_fnv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire logic        step,
    input  wire logic [7:0]  data,
    output logic [31:0]      sum
);
    logic [31:0] sum_reg;
    logic [31:0] sum_next;

    always_comb
    begin
        sum_next = sum_reg;
        if (clear)
        begin
            sum_next = lzfg_pkg::FNV_BASIS;
        end
        else if (step)
        begin
            sum_next = (sum_reg ^ {24'd0, data}) * lzfg_pkg::FNV_PRIME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= lzfg_pkg::FNV_BASIS;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;
endmodule
`default_nettype wire
